[sv/bdtsp_pkg.sv]
// ----------------------------------------------------------------------------
// bdtsp_pkg
// Shared types and constants of the bitmask tour solver.
// ----------------------------------------------------------------------------
package bdtsp_pkg;

    localparam int COST_W = 32;
    localparam logic [COST_W-1:0] COST_ALL_ONES = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ECHK,
        S_ADV,
        S_PAIR,
        S_DRAIN,
        S_WRITE,
        S_CLOSE,
        S_CDRAIN,
        S_CEND,
        S_BACK,
        S_BWAIT,
        S_EMIT,
        S_FAIL
    } state_t;

    typedef struct packed {
        logic              take;
        logic [COST_W-1:0] cand;
    } eval_t;

endpackage

[sv/bdtsp_eval.sv]
// ----------------------------------------------------------------------------
// bdtsp_eval
// Candidate path cost with saturation, and strict-minimum test against the
// best candidate held so far.
// ----------------------------------------------------------------------------
module bdtsp_eval #(
    parameter int DISTANCE_BITS = 24
) (
    input  logic [bdtsp_pkg::COST_W-1:0] base_cost,
    input  logic                         base_reached,
    input  logic                         base_start,
    input  logic [DISTANCE_BITS-1:0]     hop_len,
    input  logic                         best_reached,
    input  logic [bdtsp_pkg::COST_W-1:0] best_cost,
    output bdtsp_pkg::eval_t             result
);
    import bdtsp_pkg::*;

    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cand;
    logic              reach;

    assign sum   = {1'b0, base_cost} + (COST_W+1)'(hop_len);
    assign cand  = base_start ? COST_W'(hop_len)
                 : (sum[COST_W] ? COST_ALL_ONES : sum[COST_W-1:0]);
    assign reach = base_start | base_reached;

    assign result.cand = cand;
    assign result.take = reach && (!best_reached || (cand < best_cost));

endmodule

[sv/bitmask_dp_tsp_solver.sv]
// ----------------------------------------------------------------------------
// bitmask_dp_tsp_solver
// Held-Karp tour solver over a stored distance matrix.
// ----------------------------------------------------------------------------
// A matrix entry is taken whenever start is high while busy is low. The entry
// with load_done set starts a solve; busy stays high until the cycle that
// carries the last result. For N cities, the solve visits every odd subset
// mask from 3 up; for each end city other than city 0 in the mask it steps
// through all N candidate predecessors, one read of the cost memory per cycle,
// and it passes over an end city outside the mask. It then closes the tour
// and traces it back. No clearing pass is needed. Results then leave one per
// cycle, on valid, and the receiver cannot stall them: each one is on the
// result ports for exactly one cycle.
// ----------------------------------------------------------------------------
module bitmask_dp_tsp_solver #(
    parameter int MAX_CITIES    = 12,
    parameter int DISTANCE_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     config_we,
    input  logic [3:0]               config_data,
    input  logic                     start,
    output logic                     busy,
    input  logic [3:0]               from_city,
    input  logic [3:0]               to_city,
    input  logic [DISTANCE_BITS-1:0] distance,
    input  logic                     load_done,
    output logic                     valid,
    output logic [3:0]               tour_city,
    output logic [31:0]              total_cost,
    output logic                     found,
    output logic                     last_city_flag
);
    import bdtsp_pkg::*;

    localparam int CW     = $clog2(MAX_CITIES);
    localparam int NW     = $clog2(MAX_CITIES + 1);
    localparam int MW     = MAX_CITIES;
    localparam int DDEPTH = MAX_CITIES * MAX_CITIES;
    localparam int DAW    = $clog2(DDEPTH);
    localparam int CDEPTH = (1 << MAX_CITIES) * MAX_CITIES;
    localparam int AW     = $clog2(CDEPTH);
    localparam int WW     = 1 + COST_W + CW;

    state_t state_reg, state_next;

    logic [3:0]        city_count_reg;
    logic [NW-1:0]     n_reg, n_next;
    logic [MW-1:0]     full_reg, full_next;
    logic [MW-1:0]     mask_reg, mask_next;
    logic [CW-1:0]     e_reg, e_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     cur_reg, cur_next;
    logic              iss_v_reg, iss_v_next;
    logic              iss_s_reg, iss_s_next;
    logic [CW-1:0]     iss_k_reg, iss_k_next;
    logic              best_r_reg, best_r_next;
    logic [COST_W-1:0] best_c_reg, best_c_next;
    logic [CW-1:0]     best_i_reg, best_i_next;
    logic [CW-1:0]     seq_reg [MAX_CITIES];

    logic              valid_reg, valid_next;
    logic [3:0]        city_reg, city_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic              found_reg, found_next;
    logic              last_reg, last_next;

    logic [DISTANCE_BITS-1:0] dist_mem [DDEPTH];
    logic [WW-1:0]            cost_mem [CDEPTH];
    logic [DISTANCE_BITS-1:0] dist_rd_reg;
    logic [WW-1:0]            cost_rd_reg;
    logic [DAW-1:0]           dist_raddr, dist_waddr;
    logic [AW-1:0]            cost_raddr, cost_waddr;
    logic                     cost_we;
    logic                     seq_we;

    logic          accept;
    logic          load_ok;
    logic [NW-1:0] n_eff;
    logic [MW-1:0] e_bit, prev;
    logic [CW-1:0] n_last;
    eval_t         ev;

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign load_ok = (32'(from_city) < MAX_CITIES) && (32'(to_city) < MAX_CITIES);
    assign n_eff   = (city_count_reg == 4'd0) ? NW'(1)
                   : ((32'(city_count_reg) > MAX_CITIES) ? NW'(MAX_CITIES)
                                                         : NW'(city_count_reg));
    assign n_last  = CW'(n_reg - NW'(1));
    assign e_bit   = MW'(1) << e_reg;
    assign prev    = mask_reg ^ e_bit;

    assign dist_waddr = DAW'(from_city) * DAW'(MAX_CITIES) + DAW'(to_city);
    assign cost_waddr = AW'(mask_reg) * AW'(MAX_CITIES) + AW'(e_reg);
    assign cost_we    = (state_reg == S_WRITE);
    assign seq_we     = (state_reg == S_BACK);

    always_comb
    begin
        dist_raddr = DAW'(k_reg) * DAW'(MAX_CITIES) + DAW'(e_reg);
        cost_raddr = AW'(prev) * AW'(MAX_CITIES) + AW'(k_reg);
        case (state_reg)
            S_CLOSE:
            begin
                dist_raddr = DAW'(k_reg) * DAW'(MAX_CITIES);
                cost_raddr = AW'(full_reg) * AW'(MAX_CITIES) + AW'(k_reg);
            end
            S_BACK:
            begin
                cost_raddr = AW'(mask_reg) * AW'(MAX_CITIES) + AW'(cur_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && load_ok)
            dist_mem[dist_waddr] <= distance;
        dist_rd_reg <= dist_mem[dist_raddr];
        if (cost_we)
            cost_mem[cost_waddr] <= {best_r_reg, best_c_reg, best_i_reg};
        cost_rd_reg <= cost_mem[cost_raddr];
        if (seq_we)
            seq_reg[pos_reg] <= cur_reg;
    end

    bdtsp_eval #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_eval (
        .base_cost    (cost_rd_reg[CW +: COST_W]),
        .base_reached (cost_rd_reg[WW-1]),
        .base_start   (iss_s_reg),
        .hop_len      (dist_rd_reg),
        .best_reached (best_r_reg),
        .best_cost    (best_c_reg),
        .result       (ev)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept && load_done) state_next = S_INIT;
            S_INIT:   state_next = (n_eff < NW'(2)) ? S_FAIL : S_ECHK;
            S_ECHK:   state_next = (mask_reg[e_reg] && e_reg != '0) ? S_PAIR : S_ADV;
            S_ADV:
            begin
                if (e_reg == n_last && mask_reg == full_reg)
                    state_next = S_CLOSE;
                else
                    state_next = S_ECHK;
            end
            S_PAIR:   if (k_reg == n_last) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_WRITE;
            S_WRITE:  state_next = S_ADV;
            S_CLOSE:  if (k_reg == n_last) state_next = S_CDRAIN;
            S_CDRAIN: state_next = S_CEND;
            S_CEND:   state_next = best_r_reg ? S_BACK : S_FAIL;
            S_BACK:   state_next = (pos_reg == CW'(1)) ? S_EMIT : S_BWAIT;
            S_BWAIT:  state_next = S_BACK;
            S_EMIT:   if (pos_reg == n_last) state_next = S_IDLE;
            S_FAIL:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        n_next      = n_reg;
        full_next   = full_reg;
        mask_next   = mask_reg;
        e_next      = e_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        iss_v_next  = 1'b0;
        iss_s_next  = 1'b0;
        iss_k_next  = k_reg;
        best_r_next = best_r_reg;
        best_c_next = best_c_reg;
        best_i_next = best_i_reg;
        valid_next  = 1'b0;
        city_next   = city_reg;
        cost_next   = cost_reg;
        found_next  = found_reg;
        last_next   = last_reg;

        if (iss_v_reg && ev.take)
        begin
            best_r_next = 1'b1;
            best_c_next = ev.cand;
            best_i_next = iss_k_reg;
        end

        case (state_reg)
            S_INIT:
            begin
                n_next    = n_eff;
                full_next = (MW'(1) << n_eff) - MW'(1);
                mask_next = MW'(3);
                e_next    = CW'(1);
            end
            S_ECHK:
            begin
                k_next      = '0;
                best_r_next = 1'b0;
            end
            S_ADV:
            begin
                if (e_reg == n_last)
                begin
                    e_next = CW'(1);
                    if (mask_reg == full_reg)
                    begin
                        k_next      = CW'(1);
                        best_r_next = 1'b0;
                    end
                    else
                    begin
                        mask_next = mask_reg + MW'(2);
                    end
                end
                else
                begin
                    e_next = e_reg + CW'(1);
                end
            end
            S_PAIR:
            begin
                iss_v_next = mask_reg[k_reg] && (k_reg != e_reg)
                          && ((k_reg != '0) || (prev == MW'(1)));
                iss_s_next = (k_reg == '0);
                k_next     = k_reg + CW'(1);
            end
            S_CLOSE:
            begin
                iss_v_next = 1'b1;
                k_next     = k_reg + CW'(1);
            end
            S_CEND:
            begin
                cur_next  = best_i_reg;
                mask_next = full_reg;
                pos_next  = n_last;
            end
            S_BACK:
            begin
                mask_next = mask_reg ^ (MW'(1) << cur_reg);
                if (pos_reg == CW'(1))
                    pos_next = '0;
            end
            S_BWAIT:
            begin
                cur_next = cost_rd_reg[CW-1:0];
                pos_next = pos_reg - CW'(1);
            end
            S_EMIT:
            begin
                valid_next = 1'b1;
                city_next  = (pos_reg == '0) ? 4'd0 : 4'(seq_reg[pos_reg]);
                cost_next  = best_c_reg;
                found_next = 1'b1;
                last_next  = (pos_reg == n_last);
                pos_next   = pos_reg + CW'(1);
            end
            S_FAIL:
            begin
                valid_next = 1'b1;
                city_next  = 4'd0;
                cost_next  = COST_ALL_ONES;
                found_next = 1'b0;
                last_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            city_count_reg <= 4'd4;
            iss_v_reg      <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (config_we)
                city_count_reg <= config_data;
            iss_v_reg <= iss_v_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        full_reg   <= full_next;
        mask_reg   <= mask_next;
        e_reg      <= e_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        iss_s_reg  <= iss_s_next;
        iss_k_reg  <= iss_k_next;
        best_r_reg <= best_r_next;
        best_c_reg <= best_c_next;
        best_i_reg <= best_i_next;
        city_reg   <= city_next;
        cost_reg   <= cost_next;
        found_reg  <= found_next;
        last_reg   <= last_next;
    end

    assign valid          = valid_reg;
    assign tour_city      = city_reg;
    assign total_cost     = cost_reg;
    assign found          = found_reg;
    assign last_city_flag = last_reg;

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && load_done) |=> busy)
        else $error("solve transfer did not raise busy");

    a_mid_tour_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last_city_flag) |-> busy)
        else $error("tour result outside a solve");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last_city_flag) |=> !valid)
        else $error("result after the last city");

    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !found) |-> last_city_flag)
        else $error("failed solve gave more than one result");

    a_no_cost_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !iss_v_next)
        else $error("candidate issued while idle");

endmodule

[bench/bitmask_dp_tsp_solver_tb.sv]
// ----------------------------------------------------------------------------
// bitmask_dp_tsp_solver_tb
// Self-checking bench for the Held-Karp tour solver: loads distance matrices,
// predicts each optimal tour and its cost, and checks every emitted city.
// ----------------------------------------------------------------------------
module bitmask_dp_tsp_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdtsp_pkg::*;

    localparam int  NCITY      = 12;
    localparam int  NMASK      = 1 << NCITY;
    localparam int  CYCLE_CAP  = 4000000;

    typedef struct {
        bit [3:0]  city;
        bit [31:0] cost;
        bit        found;
        bit        last;
    } tour_step_t;

    logic        clk;
    logic        rst_n;
    logic        config_we;
    logic [3:0]  config_data;
    logic        start;
    logic        busy;
    logic [3:0]  from_city;
    logic [3:0]  to_city;
    logic [23:0] distance;
    logic        load_done;
    logic        valid;
    logic [3:0]  tour_city;
    logic [31:0] total_cost;
    logic        found;
    logic        last_city_flag;

    tour_step_t  tour_expected[$];
    int          mismatches;
    int          cycles;
    int          idle_pct;
    bit [3:0]    city_count_reg;

    bit [23:0]   dist_mem   [NCITY][NCITY];
    bit          dist_known [NCITY][NCITY];
    bit [31:0]   path_cost  [NMASK][NCITY];
    bit          path_set   [NMASK][NCITY];
    bit [3:0]    path_prev  [NMASK][NCITY];

    bitmask_dp_tsp_solver dut (
        .clk(clk), .rst_n(rst_n), .config_we(config_we), .config_data(config_data),
        .start(start), .busy(busy), .from_city(from_city), .to_city(to_city),
        .distance(distance), .load_done(load_done), .valid(valid),
        .tour_city(tour_city), .total_cost(total_cost), .found(found),
        .last_city_flag(last_city_flag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
        bit [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? COST_ALL_ONES : s[31:0];
    endfunction

    function automatic void push_no_tour();
        tour_step_t t;
        t.city = 4'd0;
        t.cost = COST_ALL_ONES;
        t.found = 1'b0;
        t.last = 1'b1;
        tour_expected.insert(tour_expected.size(), t);
    endfunction

    // Held-Karp over the stored matrix; queue the tour from city 0, or a no-tour result
    function automatic void predict_tour();
        int         n;
        int         full;
        int         best_end;
        bit         have_best;
        bit [31:0]  best_cost;
        bit [31:0]  c;
        int         prv;
        int         cur;
        int         m;
        int         seq[NCITY];
        tour_step_t t;
        n = int'(city_count_reg);
        if (n == 0) n = 1;
        if (n > NCITY) n = NCITY;
        if (n < 2)
        begin
            push_no_tour();
            return;
        end
        full = (1 << n) - 1;
        for (int i = 0; i <= full; i++)
            for (int e = 0; e < NCITY; e++)
            begin
                path_cost[i][e] = COST_ALL_ONES;
                path_set[i][e] = 1'b0;
            end
        path_cost[1][0] = 32'd0;
        path_set[1][0] = 1'b1;
        path_prev[1][0] = 4'd0;
        for (int mk = 1; mk <= full; mk++)
            for (int e = 0; e < n; e++)
            begin
                if (!mk[e]) continue;
                prv = mk ^ (1 << e);
                for (int l = 0; l < n; l++)
                begin
                    if (l == e || !mk[l] || !path_set[prv][l]) continue;
                    c = sat_sum(path_cost[prv][l], 32'(dist_mem[l][e]));
                    if (!path_set[mk][e] || c < path_cost[mk][e])
                    begin
                        path_cost[mk][e] = c;
                        path_set[mk][e] = 1'b1;
                        path_prev[mk][e] = 4'(l);
                    end
                end
            end
        have_best = 1'b0;
        best_cost = COST_ALL_ONES;
        best_end = 0;
        for (int e = 1; e < n; e++)
        begin
            if (!path_set[full][e]) continue;
            c = sat_sum(path_cost[full][e], 32'(dist_mem[e][0]));
            if (!have_best || c < best_cost)
            begin
                best_cost = c;
                best_end = e;
                have_best = 1'b1;
            end
        end
        if (!have_best)
        begin
            push_no_tour();
            return;
        end
        cur = best_end;
        m = full;
        seq[0] = 0;
        for (int p = n - 1; p >= 1; p--)
        begin
            seq[p] = cur;
            prv = int'(path_prev[m][cur]);
            m ^= (1 << cur);
            cur = prv;
        end
        for (int p = 0; p < n; p++)
        begin
            t.city = 4'(seq[p]);
            t.cost = best_cost;
            t.found = 1'b1;
            t.last = (p == n - 1);
            tour_expected.insert(tour_expected.size(), t);
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        tour_step_t t;
        if (rst_n && valid)
        begin
            if (tour_expected.size() == 0)
                report_mismatch("unexpected result, city", 32'(tour_city), 32'd0);
            else
            begin
                t = tour_expected.pop_front();
                if (tour_city != t.city)
                    report_mismatch("tour_city", 32'(tour_city), 32'(t.city));
                if (total_cost != t.cost)
                    report_mismatch("total_cost", total_cost, t.cost);
                if (found != t.found)
                    report_mismatch("found", 32'(found), 32'(t.found));
                if (last_city_flag != t.last)
                    report_mismatch("last_city_flag", 32'(last_city_flag), 32'(t.last));
            end
        end
    end

    task automatic send_entry(int fc, int tc, bit [23:0] d, bit done);
        int gap;
        @(negedge clk);
        start = 1'b1;
        from_city = 4'(fc);
        to_city = 4'(tc);
        distance = d;
        load_done = done;
        do @(posedge clk); while (busy);
        if (fc < NCITY && tc < NCITY)
        begin
            dist_mem[fc][tc] = d;
            dist_known[fc][tc] = 1'b1;
        end
        if (done) predict_tour();
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (tour_expected.size() != 0) @(posedge clk);
        do @(posedge clk); while (busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_city_count(bit [3:0] v);
        drain_results();
        @(negedge clk);
        config_we = 1'b1;
        config_data = v;
        @(negedge clk);
        config_we = 1'b0;
        city_count_reg = v;
    endtask

    function automatic bit [23:0] rand_distance();
        case ($urandom_range(3))
            0: return 24'($urandom_range(0, 15));
            1: return 24'hFFFFFF - 24'($urandom_range(0, 15));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic fill_matrix(int n, bit uniform, bit [23:0] d);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!dist_known[i][j] || uniform)
                    send_entry(i, j, uniform ? d : rand_distance(), 1'b0);
    endtask

    task automatic test_single_city();
        write_city_count(4'd0);
        send_entry(0, 0, 24'hFFFFFF, 1'b1);
        write_city_count(4'd1);
        send_entry(15, 15, 24'h000000, 1'b1);
    endtask

    task automatic test_field_extremes();
        write_city_count(4'd4);
        fill_matrix(4, 1'b1, 24'd7);
        send_entry(12, 3, 24'hAAAAAA, 1'b0);
        send_entry(2, 13, 24'h555555, 1'b0);
        send_entry(14, 15, 24'hFFFFFF, 1'b1);
        write_city_count(4'd2);
        send_entry(0, 1, 24'hFFFFFF, 1'b0);
        send_entry(1, 0, 24'hFFFFFF, 1'b1);
        write_city_count(4'd3);
        send_entry(2, 0, 24'd0, 1'b1);
    endtask

    task automatic test_max_cities();
        write_city_count(4'd15);
        fill_matrix(NCITY, 1'b0, 24'd0);
        send_entry($urandom_range(0, 11), $urandom_range(0, 11), rand_distance(), 1'b1);
    endtask

    task automatic test_random_tours();
        int n;
        int loads;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 53 : (phase == 2) ? 0 : 33;
            for (int s = 0; s < 3; s++)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(7, 8) : $urandom_range(2, 6);
                write_city_count(4'(n));
                loads = $urandom_range(0, 1);
                repeat (loads)
                    if ($urandom_range(5) == 0)
                        send_entry($urandom_range(0, 15), $urandom_range(12, 15),
                                   rand_distance(), 1'b0);
                    else
                        send_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                   rand_distance(), 1'b0);
                fill_matrix(n, 1'b0, 24'd0);
                if ($urandom_range(3) == 0)
                    send_entry($urandom_range(12, 15), $urandom_range(0, 15),
                               rand_distance(), 1'b1);
                else
                    send_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                               rand_distance(), 1'b1);
            end
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        config_we = 1'b0;
        config_data = '0;
        start = 1'b0;
        from_city = '0;
        to_city = '0;
        distance = '0;
        load_done = 1'b0;
        mismatches = 0;
        cycles = 0;
        idle_pct = 0;
        city_count_reg = 4'd4;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_city();
        test_field_extremes();
        test_random_tours();
        test_max_cities();

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/bdtsp_pkg.sv
sv/bdtsp_eval.sv
sv/bitmask_dp_tsp_solver.sv
bench/bitmask_dp_tsp_solver_tb.sv
